// ===== sv/bfdt_pkg.sv =====
// Shared types and constants for the binary fixed-point to decimal text converter.
// No dependencies.
package bfdt_pkg;

    localparam int INT_W           = 64;
    localparam int FRAC_W          = 32;
    localparam int INT_DIGITS      = 20;
    localparam int FRAC_BITS_DEF   = 32;
    localparam int FRAC_DIGITS_DEF = 6;

    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_POINT = 8'd46;

    typedef struct packed {
        logic [INT_W-1:0]  int_value;
        logic [FRAC_W-1:0] frac_value;
    } t_in_word;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } t_out_word;

    // Ten to the n, worked out at elaboration.
    function automatic logic [63:0] pow10(input int n);
        logic [63:0] acc;
        acc = 64'd1;
        for (int i = 0; i < n; i++) begin
            acc = acc * 64'd10;
        end
        return acc;
    endfunction

endpackage

// ===== sv/binary_fixed_to_decimal_text.sv =====
// Binary fixed-point to decimal ASCII text converter, top level.
// Depends on bfdt_pkg.
// Each word is accepted, multiplied, rounded, run through the 64-step double-dabble loop
// and stripped of leading zeros, then sent one character per cycle (up to 20 + 1 + DIGITS)
// while the output is taken. A new word is accepted only after the last character of the
// previous word has been issued, so words are converted one at a time.
// Reset (i_rst_n low at a clock edge, synchronous) returns the sequencer to idle
// and drops any pending output word.
module binary_fixed_to_decimal_text
    import bfdt_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int FRAC_DIGITS = FRAC_DIGITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    // Fraction handling derived from the parameters.
    localparam int KEEP   = (FRAC_BITS >= FRAC_W) ? FRAC_W : ((FRAC_BITS < 0) ? 0 : FRAC_BITS);
    localparam int DIGITS = (FRAC_DIGITS > 9) ? 9 : ((FRAC_DIGITS < 1) ? 1 : FRAC_DIGITS);
    localparam logic [63:0] SCALE = pow10(DIGITS);
    localparam int FD_W   = $clog2(SCALE);
    localparam int PW     = FRAC_W + FD_W;
    localparam int FB_W   = 4 * DIGITS;
    localparam int IB_W   = 4 * INT_DIGITS;
    localparam logic [FRAC_W-1:0] FRAC_MASK = {FRAC_W{1'b1}} << (FRAC_W - KEEP);
    localparam logic [FD_W-1:0]   SCALE_FD  = SCALE[FD_W-1:0];

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_RND  = 3'd2;
    localparam logic [2:0] S_DAB  = 3'd3;
    localparam logic [2:0] S_LEAD = 3'd4;
    localparam logic [2:0] S_INT  = 3'd5;
    localparam logic [2:0] S_DOT  = 3'd6;
    localparam logic [2:0] S_FRC  = 3'd7;

    logic [2:0]        r_state, n_state;
    logic [INT_W-1:0]  r_int,   n_int;     // integer part, later the dabble shift register
    logic [FRAC_W-1:0] r_frac,  n_frac;    // truncated fraction bits
    logic [PW-1:0]     r_prod,  n_prod;    // fraction times 10^DIGITS
    logic [FD_W-1:0]   r_fbin,  n_fbin;    // rounded fraction as a decimal integer
    logic              r_hasf,  n_hasf;
    logic [IB_W-1:0]   r_ibcd,  n_ibcd;
    logic [FB_W-1:0]   r_fbcd,  n_fbcd;
    logic [5:0]        r_cnt,   n_cnt;
    logic              r_ovalid, n_ovalid;
    t_out_word         r_odata, n_odata;

    logic            w_slot;
    logic [PW:0]     w_sum;
    logic [FD_W:0]   w_rnd;
    logic [IB_W-1:0] w_iadj;
    logic [FB_W-1:0] w_fadj;
    logic [4:0]      w_lead;
    logic            w_found;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    // The output register takes a new word when empty or when its word leaves now.
    assign w_slot = !r_ovalid || i_out_ready;

    // Round half up: add one half of the 2^32 weight and drop the low 32 bits.
    assign w_sum = {1'b0, r_prod} + (PW + 1)'(64'h8000_0000);
    assign w_rnd = w_sum[PW:FRAC_W];

    // Double-dabble correction: add three to every digit of five or more.
    always_comb begin
        w_iadj = r_ibcd;
        for (int d = 0; d < INT_DIGITS; d++) begin
            if (r_ibcd[4*d +: 4] >= 4'd5) begin
                w_iadj[4*d +: 4] = r_ibcd[4*d +: 4] + 4'd3;
            end
        end
        w_fadj = r_fbcd;
        for (int d = 0; d < DIGITS; d++) begin
            if (r_fbcd[4*d +: 4] >= 4'd5) begin
                w_fadj[4*d +: 4] = r_fbcd[4*d +: 4] + 4'd3;
            end
        end
    end

    // Count leading zero digits, keeping at least the last digit.
    always_comb begin
        w_lead  = '0;
        w_found = 1'b0;
        for (int i = 0; i < INT_DIGITS - 1; i++) begin
            if (!w_found && (r_ibcd[IB_W-1-4*i -: 4] == 4'd0)) begin
                w_lead = 5'(i + 1);
            end else begin
                w_found = 1'b1;
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_int    = r_int;
        n_frac   = r_frac;
        n_prod   = r_prod;
        n_fbin   = r_fbin;
        n_hasf   = r_hasf;
        n_ibcd   = r_ibcd;
        n_fbcd   = r_fbcd;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid && !i_out_ready;
        n_odata  = r_odata;

        case (r_state)
            S_IDLE: begin
                // Latch the word and truncate the fraction.
                if (i_in_valid) begin
                    n_int   = i_in_data.int_value;
                    n_frac  = i_in_data.frac_value & FRAC_MASK;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = PW'(r_frac) * PW'(SCALE_FD);
                n_state = S_RND;
            end
            S_RND: begin
                // A fraction that rounds to one carries into the integer part.
                if (w_rnd >= {1'b0, SCALE_FD}) begin
                    n_fbin = FD_W'(w_rnd - {1'b0, SCALE_FD});
                    n_int  = r_int + INT_W'(1);
                end else begin
                    n_fbin = w_rnd[FD_W-1:0];
                end
                n_hasf  = (r_frac != '0);
                n_ibcd  = '0;
                n_fbcd  = '0;
                n_cnt   = '0;
                n_state = S_DAB;
            end
            S_DAB: begin
                // Advance the integer lane, and the fraction lane for its first FD_W steps, by one binary bit.
                n_ibcd = {w_iadj[IB_W-2:0], r_int[INT_W-1]};
                n_int  = r_int << 1;
                if (r_cnt < 6'(FD_W)) begin
                    n_fbcd = {w_fadj[FB_W-2:0], r_fbin[FD_W-1]};
                    n_fbin = r_fbin << 1;
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(INT_W - 1)) begin
                    n_state = S_LEAD;
                end
            end
            S_LEAD: begin
                // Drop leading zeros so the first digit sits on top.
                n_ibcd  = r_ibcd << {w_lead, 2'b00};
                n_cnt   = 6'(INT_DIGITS) - 6'(w_lead);
                n_state = S_INT;
            end
            S_INT: begin
                if (w_slot) begin
                    n_ovalid          = 1'b1;
                    n_odata.char_code = CH_ZERO + 8'(r_ibcd[IB_W-1 -: 4]);
                    n_odata.last      = (r_cnt == 6'd1) && !r_hasf;
                    n_ibcd            = r_ibcd << 4;
                    n_cnt             = r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        n_state = r_hasf ? S_DOT : S_IDLE;
                    end
                end
            end
            S_DOT: begin
                if (w_slot) begin
                    n_ovalid          = 1'b1;
                    n_odata.char_code = CH_POINT;
                    n_odata.last      = 1'b0;
                    n_cnt             = 6'(DIGITS);
                    n_state           = S_FRC;
                end
            end
            S_FRC: begin
                if (w_slot) begin
                    n_ovalid          = 1'b1;
                    n_odata.char_code = CH_ZERO + 8'(r_fbcd[FB_W-1 -: 4]);
                    n_odata.last      = (r_cnt == 6'd1);
                    n_fbcd            = r_fbcd << 4;
                    n_cnt             = r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        r_int   <= n_int;
        r_frac  <= n_frac;
        r_prod  <= n_prod;
        r_fbin  <= n_fbin;
        r_hasf  <= n_hasf;
        r_ibcd  <= n_ibcd;
        r_fbcd  <= n_fbcd;
        r_cnt   <= n_cnt;
        r_odata <= n_odata;
    end

endmodule
